// ===== src/cscan_pkg.sv =====
// Package for the C-SCAN disk scheduler: transaction structs, field widths,
// register indexes and parameter defaults. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cscan_pkg;

  // Field widths fixed by the interface
  localparam int TRACK_W = 16;
  localparam int COUNT_W = 17;
  localparam int TOTAL_W = 24;
  localparam int CFG_INDEX_W = 2;

  // Parameter defaults
  localparam int MAX_REQUESTS_DEFAULT = 16;
  localparam int TRACK_BITS_DEFAULT = 16;

  // Register reset values
  localparam logic [TRACK_W-1:0] HEAD_POSITION_RESET = '0;
  localparam logic [COUNT_W-1:0] TRACK_COUNT_RESET = 17'h10000;

  // Saturation limit of the running seek total
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_HEAD_POSITION = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRACK_COUNT = 2'd1;

  // One incoming request transaction
  typedef struct packed {
    logic [TRACK_W-1:0] request_track;
    logic               final_request;
  } req_t;

  // One outgoing move transaction
  typedef struct packed {
    logic [TRACK_W-1:0] move_from;
    logic [TRACK_W-1:0] move_to;
    logic [TRACK_W-1:0] move_seek;
    logic [TOTAL_W-1:0] running_total;
    logic               range_error;
    logic               run_end;
  } res_t;

endpackage

`default_nettype wire

// ===== src/cscan_store.sv =====
// Request store: single write port, single registered read port.
// Depends on cscan_pkg for the track width.
`timescale 1ns / 1ps
`default_nettype none

module cscan_store #(
  parameter int DEPTH = cscan_pkg::MAX_REQUESTS_DEFAULT,
  parameter int IDX_W = 4
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [IDX_W-1:0]             wr_addr,
  input  wire logic [cscan_pkg::TRACK_W-1:0] wr_data,
  input  wire logic                         rd_en,
  input  wire logic [IDX_W-1:0]             rd_addr,
  output logic      [cscan_pkg::TRACK_W-1:0] rd_data
);

  logic [cscan_pkg::TRACK_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/cscan_cmp.sv =====
// Shared compare unit: decides whether the entry under scan becomes the new
// best candidate for the next move. Depends on cscan_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module cscan_cmp #(
  parameter int IDX_W = 4
) (
  input  wire logic [cscan_pkg::TRACK_W-1:0] head,
  input  wire logic                          phase_low,
  input  wire logic                          have_prev,
  input  wire logic [cscan_pkg::TRACK_W-1:0] prev_value,
  input  wire logic [IDX_W-1:0]              prev_index,
  input  wire logic                          found,
  input  wire logic [cscan_pkg::TRACK_W-1:0] best_value,
  input  wire logic [cscan_pkg::TRACK_W-1:0] cand_value,
  input  wire logic [IDX_W-1:0]              cand_index,
  output logic                               take
);

  logic in_phase;
  logic after_prev;
  logic before_best;

  // Upper sweep serves tracks at or above the head, lower sweep the rest
  assign in_phase = phase_low ? (cand_value < head) : (cand_value >= head);

  // Order is (track, slot); slots break ties between equal tracks
  assign after_prev = !have_prev || (cand_value > prev_value) ||
                      ((cand_value == prev_value) && (cand_index > prev_index));

  // Scan runs in slot order, so an equal track never beats the held best
  assign before_best = !found || (cand_value < best_value);

  assign take = in_phase && after_prev && before_best;

endmodule

`default_nettype wire

// ===== src/cscan_move.sv =====
// Seek arithmetic: absolute distance of one move and the saturating
// running total. Depends on cscan_pkg for widths and the total limit.
`timescale 1ns / 1ps
`default_nettype none

module cscan_move (
  input  wire logic [cscan_pkg::TRACK_W-1:0] pos,
  input  wire logic [cscan_pkg::TRACK_W-1:0] dest,
  input  wire logic [cscan_pkg::TOTAL_W-1:0] total,
  output logic      [cscan_pkg::TRACK_W-1:0] seek,
  output logic      [cscan_pkg::TOTAL_W-1:0] total_next
);

  logic [cscan_pkg::TOTAL_W:0] sum;

  // Absolute distance
  assign seek = (pos >= dest) ? (pos - dest) : (dest - pos);

  // Saturating accumulate
  assign sum = {1'b0, total} + (cscan_pkg::TOTAL_W + 1)'(seek);
  assign total_next = sum[cscan_pkg::TOTAL_W] ? cscan_pkg::TOTAL_MAX
                                               : sum[cscan_pkg::TOTAL_W-1:0];

endmodule

`default_nettype wire

// ===== src/cscan_disk_schedule.sv =====
// Top level of the C-SCAN disk scheduler: sequencer, configuration
// registers and result register. Depends on cscan_pkg, cscan_store,
// cscan_cmp and cscan_move.
`timescale 1ns / 1ps
`default_nettype none

// Requests are taken one per transaction while busy is low. The final
// request starts scheduling and busy stays high until the run ends: for
// every move the stored requests are scanned through the single compare
// unit, then a move state does the seek arithmetic, and a further move
// covers the jump to track 0. The last move is shown in the first cycle
// with busy low. A batch with a request beyond the disk gives its one error
// result in the cycle after its final request and costs no scheduling time.
// Each result is on result for exactly one cycle, marked by result_valid;
// the receiver must take it then, it cannot stall.
// The user must write configuration only while busy is low and no result
// is pending; the block itself does not enforce this.
module cscan_disk_schedule #(
  parameter int MAX_REQUESTS = cscan_pkg::MAX_REQUESTS_DEFAULT,
  parameter int TRACK_BITS = cscan_pkg::TRACK_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire cscan_pkg::req_t                   request,
  output cscan_pkg::res_t                        result,
  output logic                                   result_valid,
  input  wire logic                              cfg_write,
  input  wire logic [cscan_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [cscan_pkg::COUNT_W-1:0]     cfg_data
);

  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam logic [32:0] TRACK_MASK = (33'd1 << TRACK_BITS) - 33'd1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    MOVE
  } state_t;

  typedef enum logic [1:0] {
    P_UP,
    P_JUMP,
    P_LOW
  } phase_t;

  state_t state;
  phase_t phase;

  logic [cscan_pkg::TRACK_W-1:0] head_position;
  logic [cscan_pkg::COUNT_W-1:0] track_count;

  logic [CNT_W-1:0]              request_count;
  logic                          bad_request_seen;
  logic [CNT_W-1:0]              scan_i;
  logic                          have_prev;
  logic [cscan_pkg::TRACK_W-1:0] prev_value;
  logic [IDX_W-1:0]              prev_index;
  logic                          found;
  logic [cscan_pkg::TRACK_W-1:0] best_value;
  logic [IDX_W-1:0]              best_index;
  logic [cscan_pkg::TRACK_W-1:0] pos;
  logic [cscan_pkg::TOTAL_W-1:0] total;
  cscan_pkg::res_t               hold;
  logic                          hold_valid;

  logic                          accept;
  logic [cscan_pkg::TRACK_W-1:0] track;
  logic                          track_ok;
  logic                          store_ok;
  logic [cscan_pkg::COUNT_W-1:0] count_m1;
  logic [cscan_pkg::TRACK_W-1:0] last_track;
  logic                          rd_en;
  logic [cscan_pkg::TRACK_W-1:0] rd_data;
  logic [CNT_W-1:0]              scan_m1;
  logic [IDX_W-1:0]              cand_index;
  logic                          take;
  logic [cscan_pkg::TRACK_W-1:0] dest;
  logic                          emit_new;
  logic [cscan_pkg::TRACK_W-1:0] seek;
  logic [cscan_pkg::TOTAL_W-1:0] total_sum;

  // Request intake: mask to the track space and check against the disk size
  assign accept   = start && !busy;
  assign track    = request.request_track & TRACK_MASK[cscan_pkg::TRACK_W-1:0];
  assign track_ok = {1'b0, track} < track_count;
  assign store_ok = accept && track_ok && (request_count < CNT_MAX);

  // Last track, saturated to the track space
  assign count_m1   = track_count - cscan_pkg::COUNT_W'(1);
  assign last_track = (33'(count_m1) > TRACK_MASK) ? TRACK_MASK[cscan_pkg::TRACK_W-1:0]
                                                   : count_m1[cscan_pkg::TRACK_W-1:0];

  // Scan addressing: read data arrives in the cycle after its address
  assign rd_en      = (state == SCAN) && (scan_i < request_count);
  assign scan_m1    = scan_i - CNT_W'(1);
  assign cand_index = scan_m1[IDX_W-1:0];

  cscan_store #(
    .DEPTH (MAX_REQUESTS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_ok),
    .wr_addr (request_count[IDX_W-1:0]),
    .wr_data (track),
    .rd_en   (rd_en),
    .rd_addr (scan_i[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  cscan_cmp #(
    .IDX_W (IDX_W)
  ) u_cmp (
    .head       (head_position),
    .phase_low  (phase == P_LOW),
    .have_prev  (have_prev),
    .prev_value (prev_value),
    .prev_index (prev_index),
    .found      (found),
    .best_value (best_value),
    .cand_value (rd_data),
    .cand_index (cand_index),
    .take       (take)
  );

  // Destination of the move under way
  always_comb begin
    dest     = best_value;
    emit_new = 1'b1;
    case (phase)
      P_UP:    dest = found ? best_value : last_track;
      P_JUMP:  dest = '0;
      P_LOW:   emit_new = found;
      default: dest = best_value;
    endcase
  end

  cscan_move u_move (
    .pos        (pos),
    .dest       (dest),
    .total      (total),
    .seek       (seek),
    .total_next (total_sum)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_position <= cscan_pkg::HEAD_POSITION_RESET;
      track_count   <= cscan_pkg::TRACK_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        cscan_pkg::REG_HEAD_POSITION: head_position <= cfg_data[cscan_pkg::TRACK_W-1:0];
        cscan_pkg::REG_TRACK_COUNT:   track_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= IDLE;
      phase            <= P_UP;
      busy             <= 1'b0;
      request_count    <= '0;
      bad_request_seen <= 1'b0;
      result_valid     <= 1'b0;
      hold_valid       <= 1'b0;
      have_prev        <= 1'b0;
      found            <= 1'b0;
      scan_i           <= '0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (accept) begin
            if (request.final_request && (bad_request_seen || !track_ok)) begin
              // Error transaction in place of any moves
              result           <= cscan_pkg::res_t'{move_from: '0, move_to: '0,
                                                    move_seek: '0, running_total: '0,
                                                    range_error: 1'b1, run_end: 1'b1};
              result_valid     <= 1'b1;
              request_count    <= '0;
              bad_request_seen <= 1'b0;
            end else begin
              if (!track_ok) begin
                bad_request_seen <= 1'b1;
              end
              if (store_ok) begin
                request_count <= request_count + CNT_W'(1);
              end
              if (request.final_request) begin
                state      <= SCAN;
                busy       <= 1'b1;
                phase      <= P_UP;
                have_prev  <= 1'b0;
                found      <= 1'b0;
                scan_i     <= '0;
                pos        <= head_position;
                total      <= '0;
                hold_valid <= 1'b0;
              end
            end
          end
        end

        SCAN: begin
          if (scan_i != '0 && take) begin
            found      <= 1'b1;
            best_value <= rd_data;
            best_index <= cand_index;
          end
          if (scan_i == request_count) begin
            state <= MOVE;
          end else begin
            scan_i <= scan_i + CNT_W'(1);
          end
        end

        MOVE: begin
          if (emit_new) begin
            // Release the held move, keep the new one until the next is known
            if (hold_valid) begin
              result       <= hold;
              result_valid <= 1'b1;
            end
            hold       <= cscan_pkg::res_t'{move_from: pos, move_to: dest,
                                            move_seek: seek, running_total: total_sum,
                                            range_error: 1'b0, run_end: 1'b0};
            hold_valid <= 1'b1;
            pos        <= dest;
            total      <= total_sum;
            if (phase == P_UP && !found) begin
              phase <= P_JUMP;
            end else begin
              if (phase == P_JUMP) begin
                phase     <= P_LOW;
                have_prev <= 1'b0;
              end else begin
                have_prev  <= 1'b1;
                prev_value <= best_value;
                prev_index <= best_index;
              end
              state  <= SCAN;
              scan_i <= '0;
              found  <= 1'b0;
            end
          end else begin
            // Lower sweep exhausted: the held move closes the run
            result           <= cscan_pkg::res_t'{move_from: hold.move_from,
                                                  move_to: hold.move_to,
                                                  move_seek: hold.move_seek,
                                                  running_total: hold.running_total,
                                                  range_error: 1'b0, run_end: 1'b1};
            result_valid     <= 1'b1;
            hold_valid       <= 1'b0;
            request_count    <= '0;
            bad_request_seen <= 1'b0;
            state            <= IDLE;
            busy             <= 1'b0;
          end
        end

        default: begin
          state <= IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
